>>> rtl/core/sde_pkg.sv
// ----------------------------------------------------------------------------
// sde_pkg: shared constants and types for the symmetric Dirichlet energy block
// Widths of the stream fields, the wide accumulators and the divider handshake.
// ----------------------------------------------------------------------------
package sde_pkg;

	// Fixed point and face shape
	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORNERS_PER_FACE = 3;

	// Field and datapath widths
	localparam int COEF_W     = 32;
	localparam int ENERGY_W   = 48;
	localparam int JAC_W      = 64;
	localparam int ACC_W      = 128;
	localparam int OPND_W     = 33;
	localparam int PROD_W     = 66;
	localparam int AREA_ACC_W = 80;
	localparam int QCNT_W     = 7;

	// Stream widths
	localparam int S_TDATA_W = 160;
	localparam int M_TDATA_W = 104;

	// Divider request and response
	typedef struct packed {
		logic              start;
		logic [QCNT_W-1:0] qbits;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} div_rsp_t;

endpackage

>>> rtl/core/symmetric_dirichlet_energy_top.sv
// ----------------------------------------------------------------------------
// symmetric_dirichlet_energy_top: per-face symmetric Dirichlet energy, Q.F
//
//   channel | dir | beat contents
//   s_*     | in  | one triangle corner: coefficients, image coords, face area
//   m_*     | out | one face result: face energy, mesh total, flags
//
// A non-final corner is accepted, runs four products on the shared 33x33
// multiplier and drains. The final corner adds squares and determinant terms on
// the multiplier, two checks, two divisions on the shared divider (QR and 48
// quotient bits, QR = min(48 + 2F, 128 - 2F)), area products and a finish.
// s_tready is high only while idle; a result waiting in the output register
// stalls the finish. Reset clears the corner count, Jacobian sums and total.
// ----------------------------------------------------------------------------
module symmetric_dirichlet_energy_top #(
	parameter int FRAC_BITS = sde_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// d1_coef, d2_coef, u_coord, v_coord, face_area (32 bits each)
	input  logic [sde_pkg::S_TDATA_W-1:0]  s_tdata,
	// last_face
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// face_energy (48), total_energy (48), face_inverted, any_inverted,
	// saturated, zero pad (5)
	output logic [sde_pkg::M_TDATA_W-1:0]  m_tdata,
	// mesh_done
	output logic                           m_tlast
);

	localparam int AW   = sde_pkg::ACC_W;
	localparam int CW   = sde_pkg::COEF_W;
	localparam int EW   = sde_pkg::ENERGY_W;
	localparam int JW   = sde_pkg::JAC_W;
	localparam int OW   = sde_pkg::OPND_W;
	localparam int PW   = sde_pkg::PROD_W;
	localparam int FW   = sde_pkg::AREA_ACC_W;
	localparam int QW   = sde_pkg::QCNT_W;
	localparam int MDW  = sde_pkg::M_TDATA_W;
	localparam int QR_A = EW + 2*FRAC_BITS;
	localparam int QR_B = AW - 2*FRAC_BITS;
	localparam int QR   = (QR_A < QR_B) ? QR_A : QR_B;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CORNER, ST_FACE, ST_PREP, ST_CHECK,
		ST_DIV_R, ST_DIV_T, ST_AREA, ST_FINISH
	} state_t;

	typedef enum logic [1:0] {K_JAC, K_SQ, K_DET, K_AREA} mac_kind_t;
	typedef enum logic [1:0] {SH_0, SH_32, SH_64} mac_shift_t;

	typedef struct packed {
		logic       vld;
		mac_kind_t  kind;
		logic [1:0] idx;
		logic       sub;
		mac_shift_t shf;
	} mac_tag_t;

	state_t            state_q;
	logic [4:0]        step_q;
	logic [1:0]        corner_q;
	logic [JW-1:0]     jac_a_q, jac_b_q, jac_c_q, jac_d_q;
	logic [EW-1:0]     total_q;
	logic              seen_q;
	logic              inv_q;
	logic              sat_q;
	logic              m_tvalid_q;
	mac_tag_t          tag_s1;
	mac_tag_t          tag_nxt;

	logic [CW-1:0]     d1_q, d2_q, u_q, v_q, area_q;
	logic              last_q;
	logic signed [PW-1:0] mul_s1;
	logic [AW-1:0]     acc_s_q, acc_d_q, m_q;
	logic [FW-1:0]     acc_f_q;
	logic [EW-1:0]     e_q;
	logic [EW-1:0]     face_out_q, total_out_q;
	logic              finv_out_q, ainv_out_q, sat_out_q, last_out_q;

	logic signed [OW-1:0] op_a, op_b;
	logic [JW-1:0]     mx, my;
	logic [1:0]        part;
	logic signed [PW-1:0] prod_shr;
	logic [AW-1:0]     prod_ext, term;
	logic              s_acc;
	logic              corner_wrap;
	logic [EW-1:0]     s1;
	logic              s1_ovf;
	logic [AW-1:0]     n_r, n_t;
	logic              div_for_t;
	sde_pkg::div_req_t div_req;
	sde_pkg::div_rsp_t div_rsp;
	logic [AW-1:0]     div_rem, div_low;
	logic [QR-1:0]     quo;
	logic [EW:0]       e_sum;
	logic              face_ovf;
	logic              sat_final;
	logic [EW-1:0]     face_val;
	logic [EW:0]       tot_sum;
	logic [EW-1:0]     tot_next;
	logic              out_free;
	logic              out_load;

	assign s_acc       = s_tvalid && s_tready;
	assign s_tready    = (state_q == ST_IDLE);
	assign corner_wrap = (corner_q == 2'(sde_pkg::CORNERS_PER_FACE - 1));
	assign out_free    = !m_tvalid_q || m_tready;
	assign out_load    = (state_q == ST_FINISH) && out_free;

	// Pick the operands and tag for the shared multiplier
	always_comb begin
		part    = step_q[1:0];
		mx      = jac_a_q;
		my      = jac_a_q;
		op_a    = '0;
		op_b    = '0;
		tag_nxt = '0;
		case (state_q)
			ST_CORNER: begin
				op_a          = step_q[0] ? {d2_q[CW-1], d2_q} : {d1_q[CW-1], d1_q};
				op_b          = step_q[1] ? {v_q[CW-1], v_q} : {u_q[CW-1], u_q};
				tag_nxt.vld   = !step_q[2];
				tag_nxt.kind  = K_JAC;
				tag_nxt.idx   = step_q[1:0];
			end
			ST_FACE: begin
				if (!step_q[4]) begin
					case (step_q[3:2])
						2'd0:    mx = jac_a_q;
						2'd1:    mx = jac_b_q;
						2'd2:    mx = jac_c_q;
						default: mx = jac_d_q;
					endcase
					my           = mx;
					tag_nxt.kind = K_SQ;
				end else begin
					mx           = step_q[2] ? jac_b_q : jac_a_q;
					my           = step_q[2] ? jac_c_q : jac_d_q;
					tag_nxt.kind = K_DET;
					tag_nxt.sub  = step_q[2];
				end
				op_a        = part[1] ? {1'b0, mx[CW-1:0]} : {mx[JW-1], mx[JW-1:CW]};
				op_b        = part[0] ? {1'b0, my[CW-1:0]} : {my[JW-1], my[JW-1:CW]};
				tag_nxt.vld = (step_q < 5'd24);
				case (part)
					2'd0:    tag_nxt.shf = SH_64;
					2'd3:    tag_nxt.shf = SH_0;
					default: tag_nxt.shf = SH_32;
				endcase
			end
			ST_AREA: begin
				op_a         = {1'b0, area_q};
				op_b         = step_q[0] ? OW'(e_q[EW-1:CW]) : {1'b0, e_q[CW-1:0]};
				tag_nxt.vld  = (step_q < 5'd2);
				tag_nxt.kind = K_AREA;
				tag_nxt.shf  = step_q[0] ? SH_32 : SH_0;
			end
			default: begin
				tag_nxt = '0;
			end
		endcase
	end

	// Align the registered product for the accumulators
	assign prod_shr = mul_s1 >>> FRAC_BITS;
	assign prod_ext = {{(AW-PW){mul_s1[PW-1]}}, mul_s1};
	always_comb begin
		case (tag_s1.shf)
			SH_64:   term = prod_ext << 64;
			SH_32:   term = prod_ext << 32;
			default: term = prod_ext;
		endcase
	end

	// Energy terms and divider operands
	assign s1        = acc_s_q[FRAC_BITS +: EW];
	assign s1_ovf    = |acc_s_q[AW-1:EW+FRAC_BITS];
	assign n_r       = acc_s_q << FRAC_BITS;
	assign n_t       = AW'(quo) << (2*FRAC_BITS);
	assign div_for_t = (state_q == ST_DIV_R);
	assign div_rem   = div_for_t ? (n_t >> EW) : (n_r >> QR);
	assign div_low   = div_for_t ? (n_t << (AW - EW)) : (n_r << (AW - QR));
	assign div_req.qbits = div_for_t ? QW'(EW) : QW'(QR);
	assign div_req.start = ((state_q == ST_CHECK) && (m_q != '0) && !s1_ovf) ||
		((state_q == ST_DIV_R) && div_rsp.done && !div_rsp.ovf);
	assign e_sum     = {1'b0, s1} + {1'b0, quo[EW-1:0]};

	sde_div #(
		.QUO_W (QR)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.rem_init (div_rem),
		.num_low  (div_low),
		.den      (m_q),
		.rsp      (div_rsp),
		.quo      (quo)
	);

	// Face value, saturation and running total
	assign face_ovf  = |acc_f_q[FW-1:EW+FRAC_BITS+1];
	assign sat_final = sat_q || face_ovf;
	assign face_val  = sat_final ? {EW{1'b1}} : acc_f_q[FRAC_BITS+1 +: EW];
	assign tot_sum   = {1'b0, total_q} + {1'b0, face_val};
	assign tot_next  = tot_sum[EW] ? {EW{1'b1}} : tot_sum[EW-1:0];

	// Sequencer, Jacobian sums, mesh state and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			corner_q    <= '0;
			jac_a_q     <= '0;
			jac_b_q     <= '0;
			jac_c_q     <= '0;
			jac_d_q     <= '0;
			total_q     <= '0;
			seen_q      <= 1'b0;
			inv_q       <= 1'b0;
			sat_q       <= 1'b0;
			m_tvalid_q  <= 1'b0;
			tag_s1      <= '0;
			face_out_q  <= '0;
			total_out_q <= '0;
			finv_out_q  <= 1'b0;
			ainv_out_q  <= 1'b0;
			sat_out_q   <= 1'b0;
			last_out_q  <= 1'b0;
		end else begin
			tag_s1 <= tag_nxt;

			// Fold corner products into the Jacobian sums
			if (tag_s1.vld && (tag_s1.kind == K_JAC)) begin
				case (tag_s1.idx)
					2'd0:    jac_a_q <= jac_a_q + prod_shr[JW-1:0];
					2'd1:    jac_b_q <= jac_b_q + prod_shr[JW-1:0];
					2'd2:    jac_c_q <= jac_c_q + prod_shr[JW-1:0];
					default: jac_d_q <= jac_d_q + prod_shr[JW-1:0];
				endcase
			end

			// Raise valid on a new result, drop it once the beat is taken
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= ST_CORNER;
						step_q  <= '0;
					end
				end
				ST_CORNER: begin
					if (step_q == 5'd4) begin
						step_q <= '0;
						if (corner_wrap) begin
							corner_q <= '0;
							state_q  <= ST_FACE;
						end else begin
							corner_q <= corner_q + 2'd1;
							state_q  <= ST_IDLE;
						end
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_FACE: begin
					if (step_q == 5'd24) begin
						step_q  <= '0;
						jac_a_q <= '0;
						jac_b_q <= '0;
						jac_c_q <= '0;
						jac_d_q <= '0;
						state_q <= ST_PREP;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_PREP: begin
					inv_q   <= acc_d_q[AW-1];
					sat_q   <= 1'b0;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if ((m_q == '0) || s1_ovf) begin
						sat_q   <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_DIV_R;
					end
				end
				ST_DIV_R: begin
					if (div_rsp.done) begin
						if (div_rsp.ovf) begin
							sat_q   <= 1'b1;
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_DIV_T;
						end
					end
				end
				ST_DIV_T: begin
					if (div_rsp.done) begin
						if (div_rsp.ovf || e_sum[EW]) begin
							sat_q   <= 1'b1;
							state_q <= ST_FINISH;
						end else begin
							step_q  <= '0;
							state_q <= ST_AREA;
						end
					end
				end
				ST_AREA: begin
					if (step_q == 5'd2) begin
						step_q  <= '0;
						state_q <= ST_FINISH;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						face_out_q  <= face_val;
						total_out_q <= tot_next;
						finv_out_q  <= inv_q;
						ainv_out_q  <= seen_q | inv_q;
						sat_out_q   <= sat_final;
						last_out_q  <= last_q;
						total_q     <= last_q ? '0 : tot_next;
						seen_q      <= last_q ? 1'b0 : (seen_q | inv_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload: input beat, multiplier, wide accumulators
	always_ff @(posedge clk) begin
		if (s_acc) begin
			d1_q   <= s_tdata[0*CW +: CW];
			d2_q   <= s_tdata[1*CW +: CW];
			u_q    <= s_tdata[2*CW +: CW];
			v_q    <= s_tdata[3*CW +: CW];
			area_q <= s_tdata[4*CW +: CW];
			last_q <= s_tlast;
		end

		mul_s1 <= op_a * op_b;

		// Clear the face accumulators as the sums start
		if ((state_q == ST_CORNER) && (step_q == 5'd4) && corner_wrap) begin
			acc_s_q <= '0;
			acc_d_q <= '0;
		end else if (tag_s1.vld && (tag_s1.kind == K_SQ)) begin
			acc_s_q <= acc_s_q + term;
		end else if (tag_s1.vld && (tag_s1.kind == K_DET)) begin
			acc_d_q <= tag_s1.sub ? (acc_d_q - term) : (acc_d_q + term);
		end

		if ((state_q == ST_DIV_T) && div_rsp.done) begin
			acc_f_q <= '0;
			e_q     <= e_sum[EW-1:0];
		end else if (tag_s1.vld && (tag_s1.kind == K_AREA)) begin
			acc_f_q <= acc_f_q + term[FW-1:0];
		end

		// Magnitude of the determinant for the divider
		if (state_q == ST_PREP) begin
			m_q <= acc_d_q[AW-1] ? (AW'(0) - acc_d_q) : acc_d_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = last_out_q;
	assign m_tdata  = {{(MDW-2*EW-3){1'b0}}, sat_out_q, ainv_out_q, finv_out_q,
		total_out_q, face_out_q};

	// Multiplier pipe is empty whenever a new corner can be taken
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !tag_s1.vld)
		else $error("multiplier pipe busy while idle");

	// Jacobian sums are cleared at every face boundary
	a_face_sums_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && (corner_q == 2'd0) |->
		(jac_a_q == '0) && (jac_b_q == '0) && (jac_c_q == '0) && (jac_d_q == '0))
		else $error("Jacobian sums not cleared between faces");

	// Corner count stays below the face size while idle
	a_corner_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (corner_q < 2'(sde_pkg::CORNERS_PER_FACE)))
		else $error("corner count out of range");

	// A result appears only out of the finishing step
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside the finishing step");

endmodule

>>> rtl/core/sde_div.sv
// ----------------------------------------------------------------------------
// sde_div: iterative restoring divider, one quotient bit per cycle
// Takes a partial remainder that holds the numerator bits above the quotient
// field and the remaining numerator bits left aligned. Flags overflow at start
// when the quotient would not fit in the requested number of bits.
// ----------------------------------------------------------------------------
module sde_div #(
	parameter int QUO_W = 80
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sde_pkg::div_req_t               req,
	input  logic [sde_pkg::ACC_W-1:0]       rem_init,
	input  logic [sde_pkg::ACC_W-1:0]       num_low,
	input  logic [sde_pkg::ACC_W-1:0]       den,
	output sde_pkg::div_rsp_t               rsp,
	output logic [QUO_W-1:0]                quo
);

	localparam int AW = sde_pkg::ACC_W;
	localparam int QW = sde_pkg::QCNT_W;

	logic          busy_q;
	logic          done_q;
	logic          ovf_q;
	logic [QW-1:0] cnt_q;
	logic [AW-1:0] rem_q;
	logic [AW-1:0] low_q;
	logic [AW-1:0] den_q;
	logic [QUO_W-1:0] quo_q;
	logic [AW-1:0] rem_sh;
	logic          take;
	logic          init_ovf;

	// Shift in the next numerator bit and try the subtract
	assign rem_sh   = {rem_q[AW-2:0], low_q[AW-1]};
	assign take     = (rem_sh >= den_q);
	assign init_ovf = (rem_init >= den);

	// Control: count quotient bits, flag done and overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= req.qbits;
				ovf_q <= init_ovf;
				if (init_ovf) begin
					done_q <= 1'b1;
					busy_q <= 1'b0;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - QW'(1);
				if (cnt_q == QW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder, numerator tail and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= den;
			rem_q <= rem_init;
			low_q <= num_low;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? (rem_sh - den_q) : rem_sh;
			low_q <= {low_q[AW-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], take};
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign quo      = quo_q;

endmodule
